/* design/multichannel_periodic_oneshot_timer_unit_assert.svh */
// ----------------------------------------------------------------------------
// multichannel periodic/one-shot timer - assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PERIODIC_ONESHOT_TIMER_UNIT_ASSERT_SVH
`define MULTICHANNEL_PERIODIC_ONESHOT_TIMER_UNIT_ASSERT_SVH

`ifndef SYNTH
// check that is switched off while reset is high
`define MPOT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs through reset
`define MPOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPOT_ASSERT(lbl, clk, rst, prop, msg)
`define MPOT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* design/mpot_pkg.sv */
// ----------------------------------------------------------------------------
// mpot_pkg
// shared types, codes and helpers of the multichannel timer unit
// ----------------------------------------------------------------------------
package mpot_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int CH_W         = 4;
  localparam int TICK_W       = 32;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_CREATE     = 3'd1,
    MODE_DELETE     = 3'd2,
    MODE_ADD_DELAY  = 3'd3,
    MODE_STOP_DELAY = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_INIT    = 2'd0,
    KIND_EXISTS  = 2'd1,
    KIND_DLY_EXP = 2'd2,
    KIND_PER_EXP = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [CH_W-1:0]   channel;
    logic [TICK_W-1:0] interval_ms;
    logic [TICK_W-1:0] now_tick;
  } req_t;

  typedef struct packed {
    logic [CH_W-1:0] event_channel;
    logic [1:0]      event_kind;
    logic            channel_active;
    logic            last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DLY,
    ST_PER,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic chk_dly;
    logic chk_per;
    logic flush;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_go;
    logic idx_last;
  } dp_sts_t;

  // wrapped signed difference at most zero
  function automatic logic deadline_reached(input logic [TICK_W-1:0] deadline,
                                            input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] diff;
    diff = deadline - now;
    return (diff == '0) || diff[TICK_W-1];
  endfunction

endpackage

/* design/multichannel_periodic_oneshot_timer_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_periodic_oneshot_timer_unit
// per-channel periodic timers and one-shot delays against a 32-bit ms tick
// ----------------------------------------------------------------------------
//
// channel   handshake              payload
// -------   ---------------------  ------------------------------------------
// request   start in, busy out     mode, channel, interval_ms, now_tick
// result    result_strobe out      event_channel, event_kind, channel_active,
//                                  last
//
// a command transaction (create, delete, add/stop delay, unchanged tick) does
// not make the block busy; a create result shows in the cycle after acceptance
// a tick with a new value walks the channels one check per cycle, a delay
// check then a periodic check per channel through the deadline compare,
// then flushes, with busy high throughout; results of a tick leave one per
// cycle at most, held one deep so that the final one can carry last
// reset (rst, synchronous) clears the stored tick, periods, delay arms and active flags
// the receiver cannot stall: each result is valid for its strobe cycle only
//
module multichannel_periodic_oneshot_timer_unit
  import mpot_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst,
  // request side
  input  logic start,
  output logic busy,
  input  req_t request,
  // result side
  output logic result_strobe,
  output rsp_t result
);

  // controller and datapath talk only through these two groups
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: decides when a transaction is taken and steps the scan
  mpot_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (dp_sts),
    .cmd   (dp_cmd)
  );

  // timer stores, expiry compare, re-arm adder and result registers
  mpot_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

/* design/mpot_ctrl.sv */
// ----------------------------------------------------------------------------
// mpot_ctrl
// sequencer: idle, delay check, periodic check per channel, final flush
// ----------------------------------------------------------------------------
module mpot_ctrl
  import mpot_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  state_next = (start && sts.tick_go) ? ST_DLY : ST_IDLE;
      ST_DLY:   state_next = ST_PER;
      ST_PER:   state_next = sts.idx_last ? ST_FLUSH : ST_DLY;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_DLY:   cmd.chk_dly = 1'b1;
      ST_PER:   cmd.chk_per = 1'b1;
      ST_FLUSH: cmd.flush   = 1'b1;
      default:  cmd         = '0;
    endcase
  end

endmodule

/* design/mpot_dp.sv */
// ----------------------------------------------------------------------------
// mpot_dp
// per-channel timer state, deadline compare and one-deep result hold
// ----------------------------------------------------------------------------
`include "multichannel_periodic_oneshot_timer_unit_assert.svh"

module mpot_dp
  import mpot_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    request,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output rsp_t    result,
  output logic    result_strobe
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TICK_W-1:0] seen_tick;
  logic [TICK_W-1:0] period            [CHANNELS];
  logic [TICK_W-1:0] periodic_deadline [CHANNELS];
  logic [TICK_W-1:0] delay_deadline    [CHANNELS];
  logic              delay_armed       [CHANNELS];
  logic              task_active       [CHANNELS];

  logic [IDX_W-1:0] idx;
  logic             hold_valid;
  rsp_t             hold;

  logic             cmd_ok;
  logic [IDX_W-1:0] cmd_idx;
  logic             dly_hit;
  logic             per_hit;
  logic             new_hit;
  rsp_t             new_rsp;

  always_comb begin
    cmd_ok       = 32'(request.channel) < 32'(CHANNELS);
    cmd_idx      = IDX_W'(request.channel);
    sts.tick_go  = (request.mode == MODE_TICK) && (request.now_tick != seen_tick);
    sts.idx_last = 32'(idx) == 32'(CHANNELS - 1);
    dly_hit = cmd.chk_dly && delay_armed[idx] &&
              deadline_reached(delay_deadline[idx], seen_tick);
    per_hit = cmd.chk_per && (period[idx] != '0) &&
              deadline_reached(periodic_deadline[idx], seen_tick);
    new_hit = dly_hit || per_hit;
    new_rsp.event_channel  = CH_W'(idx);
    new_rsp.event_kind     = dly_hit ? KIND_DLY_EXP : KIND_PER_EXP;
    new_rsp.channel_active = task_active[idx];
    new_rsp.last           = 1'b0;
  end

  // control state and reset-cleared stores
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_tick     <= '0;
      idx           <= '0;
      hold_valid    <= 1'b0;
      result_strobe <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        period[i]      <= '0;
        delay_armed[i] <= 1'b0;
        task_active[i] <= 1'b0;
      end
    end else begin
      // create reply, or a held result pushed out by a new hit or the flush
      result_strobe <= (cmd.accept && cmd_ok && (request.mode == MODE_CREATE)) ||
                       ((new_hit || cmd.flush) && hold_valid);
      if (cmd.accept) begin
        if (request.mode == MODE_TICK) begin
          if (sts.tick_go) begin
            seen_tick <= request.now_tick;
            idx       <= '0;
          end
        end else if (cmd_ok) begin
          case (mode_t'(request.mode))
            MODE_CREATE: begin
              period[cmd_idx]      <= request.interval_ms;
              task_active[cmd_idx] <= 1'b1;
            end
            MODE_DELETE: begin
              period[cmd_idx]      <= '0;
              task_active[cmd_idx] <= 1'b0;
            end
            MODE_ADD_DELAY:  delay_armed[cmd_idx] <= 1'b1;
            MODE_STOP_DELAY: delay_armed[cmd_idx] <= 1'b0;
            default: ;
          endcase
        end
      end
      if (dly_hit) begin
        delay_armed[idx] <= 1'b0;
      end
      if (cmd.chk_per && !sts.idx_last) begin
        idx <= IDX_W'(idx + 1'b1);
      end
      // a new hit pushes the held one out, not yet the last
      if (new_hit) begin
        hold_valid <= 1'b1;
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // payload stores, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept && (request.mode != MODE_TICK) && cmd_ok) begin
      case (mode_t'(request.mode))
        MODE_CREATE: begin
          periodic_deadline[cmd_idx] <= seen_tick + request.interval_ms;
          result.event_channel       <= request.channel;
          result.event_kind          <= task_active[cmd_idx] ? KIND_EXISTS : KIND_INIT;
          result.channel_active      <= 1'b1;
          result.last                <= 1'b1;
        end
        MODE_ADD_DELAY:  delay_deadline[cmd_idx] <= seen_tick + request.interval_ms;
        MODE_STOP_DELAY: delay_deadline[cmd_idx] <= '0;
        default: ;
      endcase
    end
    if (per_hit) begin
      periodic_deadline[idx] <= seen_tick + period[idx];
    end
    if (new_hit) begin
      hold <= new_rsp;
      if (hold_valid) begin
        result <= hold;
      end
    end
    if (cmd.flush && hold_valid) begin
      result <= '{event_channel:  hold.event_channel,
                  event_kind:     hold.event_kind,
                  channel_active: hold.channel_active,
                  last:           1'b1};
    end
  end

  `MPOT_ASSERT(a_hold_empty_on_accept, clk, rst, cmd.accept |-> !hold_valid, "hold not empty")
  `MPOT_ASSERT(a_flush_drains_hold, clk, rst, cmd.flush |=> !hold_valid, "hold full after flush")
  `MPOT_ASSERT(a_idx_in_range, clk, rst, 32'(idx) < 32'(CHANNELS), "scan index out of range")
  `MPOT_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!result_strobe && !hold_valid), "reset result")

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - multichannel periodic/one-shot timer unit testbench
// drives command and tick transactions through the start/busy handshake,
// predicts every timer event in a small scoreboard and checks each strobed
// result, in order, field by field
// ----------------------------------------------------------------------------
module tb
  import mpot_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // modes the block must ignore
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 480;
  // no idling once the run gets this far
  localparam int unsigned TAIL_START   = 400;
  // ample settling time after the last tick walk
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the timer state, queue of events still to come
  // --------------------------------------------------------------------------
  class timer_event_scoreboard;
    logic [31:0] tick_seen;
    logic [31:0] per_period [CHANNELS_DEF];
    logic [31:0] per_due    [CHANNELS_DEF];
    logic [31:0] dly_due    [CHANNELS_DEF];
    bit          dly_armed  [CHANNELS_DEF];
    bit          task_on    [CHANNELS_DEF];
    rsp_t        due_events [$];
    int unsigned errors;
    int unsigned events_seen;
    int unsigned busiest;
    int unsigned kind_seen [4];

    function new();
      tick_seen = '0;
      foreach (per_period[i]) begin
        per_period[i] = '0;
        per_due[i]    = '0;
        dly_due[i]    = '0;
        dly_armed[i]  = 1'b0;
        task_on[i]    = 1'b0;
      end
      foreach (kind_seen[i]) kind_seen[i] = 0;
      errors      = 0;
      events_seen = 0;
      busiest     = 0;
    endfunction

    // deadline reached when (deadline - tick) is zero or negative, wrapped
    function bit expired(logic [31:0] deadline);
      logic [31:0] gap;
      gap = deadline - tick_seen;
      return $signed(gap) <= 0;
    endfunction

    function rsp_t make_event(int unsigned ch, kind_t k);
      rsp_t ev;
      ev.event_channel  = CH_W'(ch);
      ev.event_kind     = k;
      ev.channel_active = task_on[ch];
      ev.last           = 1'b0;
      return ev;
    endfunction

    function void note_command(req_t r);
      rsp_t        evs [$];
      int unsigned ch;
      ch = 32'(r.channel);
      if (r.mode == MODE_TICK) begin
        // unchanged tick does nothing
        if (r.now_tick != tick_seen) begin
          tick_seen = r.now_tick;
          for (int unsigned i = 0; i < CHANNELS_DEF; i++) begin
            if (dly_armed[i] && expired(dly_due[i])) begin
              dly_armed[i] = 1'b0;
              evs.push_back(make_event(i, KIND_DLY_EXP));
            end
            if (per_period[i] != '0 && expired(per_due[i])) begin
              per_due[i] = tick_seen + per_period[i];
              evs.push_back(make_event(i, KIND_PER_EXP));
            end
          end
        end
      end else if (ch < CHANNELS_DEF) begin
        case (r.mode)
          MODE_CREATE: begin
            per_period[ch] = r.interval_ms;
            per_due[ch]    = tick_seen + r.interval_ms;
            if (!task_on[ch]) begin
              task_on[ch] = 1'b1;
              evs.push_back(make_event(ch, KIND_INIT));
            end else begin
              evs.push_back(make_event(ch, KIND_EXISTS));
            end
          end
          MODE_DELETE: begin
            task_on[ch]    = 1'b0;
            per_period[ch] = '0;
          end
          MODE_ADD_DELAY: begin
            dly_due[ch]   = tick_seen + r.interval_ms;
            dly_armed[ch] = 1'b1;
          end
          MODE_STOP_DELAY: begin
            dly_due[ch]   = '0;
            dly_armed[ch] = 1'b0;
          end
          default: ;
        endcase
      end
      if (evs.size() != 0) begin
        evs[evs.size()-1].last = 1'b1;
        if (evs.size() > busiest) busiest = evs.size();
        foreach (evs[k]) due_events.push_back(evs[k]);
      end
    endfunction

    function void check_event(rsp_t got);
      rsp_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected result: channel %0d kind %0d active %0b last %0b",
                 $time, got.event_channel, got.event_kind, got.channel_active, got.last);
        errors++;
        return;
      end
      want = due_events.pop_front();
      events_seen++;
      kind_seen[want.event_kind]++;
      if (got.event_channel !== want.event_channel) begin
        $display("%0t: event_channel expected %0d actual %0d",
                 $time, want.event_channel, got.event_channel);
        errors++;
      end
      if (got.event_kind !== want.event_kind) begin
        $display("%0t: event_kind (channel %0d) expected %0d actual %0d",
                 $time, want.event_channel, want.event_kind, got.event_kind);
        errors++;
      end
      if (got.channel_active !== want.channel_active) begin
        $display("%0t: channel_active (channel %0d) expected %0b actual %0b",
                 $time, want.event_channel, want.channel_active, got.channel_active);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last (channel %0d) expected %0b actual %0b",
                 $time, want.event_channel, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic result_strobe;
  rsp_t result;

  multichannel_periodic_oneshot_timer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result)
  );

  timer_event_scoreboard sb;

  // stimulus side view of the tick, so ticks can be made to move forward
  logic [31:0] stim_tick;
  int unsigned sent;
  int unsigned useful;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, sb.due_events.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // results cannot be held off: take each one on its strobe cycle
  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_event(result);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // present one transaction and hold it until the block takes it
  task automatic send_item(req_t r);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge: predict its events now
    sb.note_command(r);
    sent++;
    if (r.mode == MODE_TICK) stim_tick = r.now_tick;
  endtask

  task automatic idle_gap(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender holds back until every predicted event has come out
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.due_events.size() != 0);
  endtask

  function automatic req_t make_req(logic [2:0] mode, int unsigned ch,
                                    logic [31:0] ms, logic [31:0] now);
    req_t r;
    r.mode        = mode;
    r.channel     = CH_W'(ch);
    r.interval_ms = ms;
    r.now_tick    = now;
    return r;
  endfunction

  // mostly short intervals so that deadlines actually come due,
  // with full-range values and the signed-boundary cases mixed in
  function automatic logic [31:0] pick_interval();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(16);
    if (sel < 75) return $urandom_range(100, 17);
    if (sel < 90) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // small steps dominate; some repeats, long jumps and half-range jumps
  function automatic logic [31:0] pick_next_tick();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return stim_tick;
    if (sel < 75) return stim_tick + $urandom_range(8, 1);
    if (sel < 85) return stim_tick + $urandom_range(64, 9);
    if (sel < 95) return $urandom;
    return stim_tick + 32'h7FFF_FFFF + $urandom_range(2);
  endfunction

  function automatic req_t random_command();
    req_t        r;
    int unsigned sel;
    // ignored fields still carry random content
    r.channel     = CH_W'($urandom_range(15));
    r.interval_ms = $urandom;
    r.now_tick    = $urandom;
    sel = $urandom_range(99);
    if (sel < 38) begin
      r.mode     = MODE_TICK;
      r.now_tick = pick_next_tick();
    end else if (sel < 58) begin
      r.mode        = MODE_CREATE;
      r.interval_ms = pick_interval();
    end else if (sel < 66) begin
      r.mode = MODE_DELETE;
    end else if (sel < 86) begin
      r.mode        = MODE_ADD_DELAY;
      r.interval_ms = pick_interval();
    end else if (sel < 96) begin
      r.mode = MODE_STOP_DELAY;
    end else begin
      r.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    end
    return r;
  endfunction

  // every channel gets a period-1 task and a 1-tick delay, then one tick:
  // the busiest possible walk, with both events on every channel
  task automatic run_full_walk();
    wait_for_drain();
    for (int unsigned ch = 0; ch < CHANNELS_DEF; ch++) begin
      send_item(make_req(MODE_CREATE, ch, 32'd1, $urandom));
      send_item(make_req(MODE_ADD_DELAY, ch, 32'd1, $urandom));
    end
    send_item(make_req(MODE_TICK, $urandom_range(15), $urandom, stim_tick + 1));
    wait_for_drain();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    req_t r;
    bit   counts;
    bit   gaps_on;
    bit   walk_done;

    sb        = new();
    stim_tick = '0;
    sent      = 0;
    useful    = 0;
    gaps_on   = 1'b0;
    walk_done = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part
    // tick equal to the reset value: nothing happens
    send_item(make_req(MODE_TICK, 9, 32'hFFFF_FFFF, 32'h0));
    // zero period task, then the same channel again reports exists
    send_item(make_req(MODE_CREATE, 0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_req(MODE_CREATE, 0, 32'd5, 32'h0));
    send_item(make_req(MODE_CREATE, 15, 32'd3, 32'h0));
    send_item(make_req(MODE_ADD_DELAY, 7, 32'd2, 32'h0));
    // delay of all ones lands behind the current tick
    send_item(make_req(MODE_ADD_DELAY, 8, 32'hFFFF_FFFF, 32'h0));
    send_item(make_req(MODE_ADD_DELAY, 9, 32'd10, 32'h0));
    send_item(make_req(MODE_STOP_DELAY, 9, 32'h0, 32'h0));
    // spare modes are dropped
    send_item(make_req(MODE_SPARE_LO, 3, 32'd1, 32'd1));
    send_item(make_req(MODE_SPARE_HI, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(MODE_TICK, 0, 32'h0, 32'd3));
    // same tick again
    send_item(make_req(MODE_TICK, 0, 32'h0, 32'd3));
    send_item(make_req(MODE_DELETE, 15, 32'h0, 32'h0));
    // recreate after delete reports init; all-ones period
    send_item(make_req(MODE_CREATE, 15, 32'hFFFF_FFFF, 32'h0));
    // half-range jump, sign of the wrapped difference flips
    send_item(make_req(MODE_TICK, 0, 32'h0, 32'h8000_0003));
    send_item(make_req(MODE_CREATE, 3, 32'h7FFF_FFFF, 32'h0));
    send_item(make_req(MODE_CREATE, 4, 32'h8000_0000, 32'h0));
    send_item(make_req(MODE_ADD_DELAY, 0, 32'h8000_0000, 32'h0));
    // commands use the stored tick, not now_tick
    send_item(make_req(MODE_ADD_DELAY, 5, 32'd1, 32'h1234_5678));
    send_item(make_req(MODE_TICK, 0, 32'h0, 32'hFFFF_FFFF));
    // wrap through zero
    send_item(make_req(MODE_TICK, 0, 32'h0, 32'h0));
    send_item(make_req(MODE_DELETE, 3, 32'h0, 32'h0));
    send_item(make_req(MODE_TICK, 0, 32'h0, 32'h8000_0000));
    wait_for_drain();

    // random part
    while (sent < RANDOM_ITEMS) begin
      // gaps switch on and off in stretches
      if (sent % 32 == 0) gaps_on = $urandom_range(1);
      if (sent % 150 == 0) wait_for_drain();
      if (!walk_done && sent >= RANDOM_ITEMS / 2) begin
        run_full_walk();
        walk_done = 1'b1;
      end
      r = random_command();
      // spare modes and repeated ticks are ignored by the block
      counts = !(r.mode >= MODE_SPARE_LO ||
                 (r.mode == MODE_TICK && r.now_tick == stim_tick));
      send_item(r);
      if (counts) useful++;
      if (gaps_on && sent < TAIL_START && $urandom_range(2) == 0)
        idle_gap($urandom_range(19, 1));
    end

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);

    $display("run: %0d transactions sent, %0d random ones that changed state, %0d results",
             sent, useful, sb.events_seen);
    $display("events: init %0d, exists %0d, delay expiry %0d, periodic expiry %0d, busiest tick %0d",
             sb.kind_seen[KIND_INIT], sb.kind_seen[KIND_EXISTS],
             sb.kind_seen[KIND_DLY_EXP], sb.kind_seen[KIND_PER_EXP], sb.busiest);
    if (sb.errors == 0 && sb.due_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* multichannel_periodic_oneshot_timer_unit.f */
+incdir+design
design/mpot_pkg.sv
design/mpot_ctrl.sv
design/mpot_dp.sv
design/multichannel_periodic_oneshot_timer_unit.sv
bench/tb.sv
